FILE: src/mcuup_pkg.sv
// Package for the 4:2:0 MCU upsampler: payload types, constants and helper functions.
package mcuup_pkg;

  // Coordinate width of the produced pixel position
  localparam int COORD_BITS = 12;

  // Depth of the queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Sample kinds
  localparam logic [1:0] CMD_CB = 2'd0;
  localparam logic [1:0] CMD_CR = 2'd1;
  localparam logic [1:0] CMD_Y  = 2'd2;

  // Q16 colour conversion coefficients
  localparam logic signed [26:0] Q_CR_R = 27'sd91881;
  localparam logic signed [26:0] Q_CB_G = 27'sd22554;
  localparam logic signed [26:0] Q_CR_G = 27'sd46802;
  localparam logic signed [26:0] Q_CB_B = 27'sd116130;

  // Input item
  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [11:0] sample;
    logic [5:0]        position;
    logic [1:0]        block_in_mcu;
  } in_t;

  // Result item
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_row;
    logic [COORD_BITS-1:0] pixel_col;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  end_of_mcu;
  } out_t;

  // One luma pixel with its co-sited chroma, as queued for conversion
  typedef struct packed {
    logic [7:0]            y;
    logic [7:0]            cb;
    logic [7:0]            cr;
    logic [COORD_BITS-1:0] prow;
    logic [COORD_BITS-1:0] pcol;
    logic                  last;
  } work_t;

  // Queue status seen by the front, the back and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Level shift by 128 and clamp to 0..255
  function automatic logic [7:0] level_clamp(input logic signed [11:0] sample);
    logic signed [12:0] s;
    s = 13'(sample) + 13'sd128;
    if (s < 0) begin
      return 8'd0;
    end else if (s > 13'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  // Clamp a shifted colour sum to 0..255
  function automatic logic [7:0] clamp8(input logic signed [10:0] v);
    if (v < 0) begin
      return 8'd0;
    end else if (v > 11'sd255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  // Fit a 12-bit coordinate to the coordinate width
  function automatic logic [COORD_BITS-1:0] coord_fit(input logic [11:0] v);
    logic [15:0] w;
    w = {4'b0, v};
    return w[COORD_BITS-1:0];
  endfunction

endpackage

FILE: src/mcuup_front.sv
// Front end: accepts items, stores chroma, tracks MCU position and fetches co-sited chroma.
module mcuup_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [8:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  mcuup_pkg::in_t   in_item,
  output logic             push,
  output mcuup_pkg::work_t push_item,
  input  mcuup_pkg::qstat_t qstat
);

  logic [7:0] cb_mem [64];
  logic [7:0] cr_mem [64];
  logic [7:0] cb_rd;
  logic [7:0] cr_rd;

  logic [8:0] mcus_per_row;
  logic [7:0] mcu_column;
  logic [7:0] mcu_row;

  logic                            s1_valid;
  logic [7:0]                      s1_y;
  logic [mcuup_pkg::COORD_BITS-1:0] s1_prow;
  logic [mcuup_pkg::COORD_BITS-1:0] s1_pcol;
  logic                            s1_last;

  logic       s1_en;
  logic       accept;
  logic       is_y;
  logic       last;
  logic [7:0] level;
  logic [5:0] cidx;

  // Handshake and item decode
  always_comb begin
    s1_en    = !s1_valid || !qstat.full;
    in_stall = !s1_en;
    accept   = in_valid && !in_stall;
    is_y     = (in_item.cmd == mcuup_pkg::CMD_Y);
    level    = mcuup_pkg::level_clamp(in_item.sample);
    last     = (in_item.block_in_mcu == 2'd3) && (in_item.position == 6'd63);
    cidx     = {in_item.block_in_mcu[1], in_item.position[5:4],
                in_item.block_in_mcu[0], in_item.position[2:1]};
  end

  // Chroma stores: write on chroma items, registered read on luma items
  always_ff @(posedge clk) begin
    if (accept && in_item.cmd == mcuup_pkg::CMD_CB) begin
      cb_mem[in_item.position] <= level;
    end
    if (accept && in_item.cmd == mcuup_pkg::CMD_CR) begin
      cr_mem[in_item.position] <= level;
    end
    if (accept && is_y) begin
      cb_rd <= cb_mem[cidx];
      cr_rd <= cr_mem[cidx];
    end
  end

  // Luma stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= accept && is_y;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_y) begin
      s1_y    <= level;
      s1_prow <= mcuup_pkg::coord_fit({mcu_row, in_item.block_in_mcu[1],
                                       in_item.position[5:3]});
      s1_pcol <= mcuup_pkg::coord_fit({mcu_column, in_item.block_in_mcu[0],
                                       in_item.position[2:0]});
      s1_last <= last;
    end
  end

  // MCU position counters; a register write restarts them
  always_ff @(posedge clk) begin
    if (rst) begin
      mcus_per_row <= 9'd1;
      mcu_column   <= 8'd0;
      mcu_row      <= 8'd0;
    end else if (cfg_we) begin
      mcus_per_row <= cfg_data;
      mcu_column   <= 8'd0;
      mcu_row      <= 8'd0;
    end else if (accept && is_y && last) begin
      if (({1'b0, mcu_column} + 9'd1 == mcus_per_row) || (mcu_column == 8'hFF)) begin
        mcu_column <= 8'd0;
        mcu_row    <= mcu_row + 8'd1;
      end else begin
        mcu_column <= mcu_column + 8'd1;
      end
    end
  end

  // Transfer into the queue
  always_comb begin
    push           = s1_valid && !qstat.full;
    push_item.y    = s1_y;
    push_item.cb   = cb_rd;
    push_item.cr   = cr_rd;
    push_item.prow = s1_prow;
    push_item.pcol = s1_pcol;
    push_item.last = s1_last;
  end

endmodule

FILE: src/mcuup_queue.sv
// Short queue of luma work items between the front end and the colour converter.
module mcuup_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mcuup_pkg::work_t  push_item,
  input  logic              pop,
  output mcuup_pkg::work_t  head,
  output mcuup_pkg::qstat_t qstat
);

  mcuup_pkg::work_t               slots [mcuup_pkg::QDEPTH];
  logic [mcuup_pkg::QPTR_W-1:0]   wr_ptr;
  logic [mcuup_pkg::QPTR_W-1:0]   rd_ptr;
  logic [mcuup_pkg::QPTR_W:0]     count;
  logic                           do_push;
  logic                           do_pop;

  always_comb begin
    qstat.full  = (count == (mcuup_pkg::QPTR_W+1)'(mcuup_pkg::QDEPTH));
    qstat.empty = (count == '0);
    do_push     = push && !qstat.full;
    do_pop      = pop && !qstat.empty;
    head        = slots[rd_ptr];
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: src/mcuup_back.sv
// Back end: Q16 YCbCr to RGB conversion in two stages, a product stage and an output register.
module mcuup_back (
  input  logic              clk,
  input  logic              rst,
  input  mcuup_pkg::work_t  head,
  input  mcuup_pkg::qstat_t qstat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output mcuup_pkg::out_t   out_item
);

  // Product stage
  logic                             a_valid;
  logic [7:0]                       a_y;
  logic signed [26:0]               a_rr;
  logic signed [26:0]               a_gb;
  logic signed [26:0]               a_gr;
  logic signed [26:0]               a_bb;
  logic [mcuup_pkg::COORD_BITS-1:0] a_prow;
  logic [mcuup_pkg::COORD_BITS-1:0] a_pcol;
  logic                             a_last;

  logic              out_en;
  logic              a_en;
  logic signed [7:0] dcb;
  logic signed [7:0] dcr;
  logic signed [26:0] ys;
  logic signed [26:0] sum_r;
  logic signed [26:0] sum_g;
  logic signed [26:0] sum_b;

  always_comb begin
    out_en = !out_valid || !out_stall;
    a_en   = !a_valid || out_en;
    pop    = a_en && !qstat.empty;
    // chroma minus 128 is the chroma with its top bit flipped
    dcb    = $signed({~head.cb[7], head.cb[6:0]});
    dcr    = $signed({~head.cr[7], head.cr[6:0]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_y    <= head.y;
      a_rr   <= 27'(dcr) * mcuup_pkg::Q_CR_R;
      a_gb   <= 27'(dcb) * mcuup_pkg::Q_CB_G;
      a_gr   <= 27'(dcr) * mcuup_pkg::Q_CR_G;
      a_bb   <= 27'(dcb) * mcuup_pkg::Q_CB_B;
      a_prow <= head.prow;
      a_pcol <= head.pcol;
      a_last <= head.last;
    end
  end

  // Sums, arithmetic shift by 16 and clamp
  always_comb begin
    ys    = $signed({3'b000, a_y, 16'h0000});
    sum_r = ys + a_rr;
    sum_g = ys - a_gb - a_gr;
    sum_b = ys + a_bb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && a_valid) begin
      out_item.pixel_row  <= a_prow;
      out_item.pixel_col  <= a_pcol;
      out_item.red        <= mcuup_pkg::clamp8(sum_r[26:16]);
      out_item.green      <= mcuup_pkg::clamp8(sum_g[26:16]);
      out_item.blue       <= mcuup_pkg::clamp8(sum_b[26:16]);
      out_item.end_of_mcu <= a_last;
    end
  end

endmodule

FILE: src/mcu_420_upsample_ycbcr_to_rgb_unit.sv
// Top level of the 4:2:0 MCU chroma upsampler and YCbCr to RGB converter.
//
// Input channel (in_valid / in_stall / in_item): one IDCT sample per transfer.
// Cb and Cr samples are level-shifted, clamped and stored by position; they
// produce no pixel. A luma sample produces one RGB pixel with its image row
// and column, using the co-sited chroma of its 2x2 quadrant. Unused sample
// kinds are taken and dropped.
// Output channel (out_valid / out_stall / out_item): one pixel per transfer.
// Configuration: cfg_we writes cfg_data to mcus_per_row and restarts the MCU
// counters; write only while the block is idle.
// Path: a luma sample passes the front register, the queue, the product stage
// and the output register, in that order.
// Throughput: one item per clock while in_stall is low.
// Reset: MCU counters to zero, mcus_per_row to 1, queue and pipeline empty;
// chroma stores hold nothing defined until written.
// A stall on the output holds the result; the four-entry queue absorbs the
// pipeline, then in_stall rises until the output drains.
module mcu_420_upsample_ycbcr_to_rgb_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [8:0]      cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  mcuup_pkg::in_t  in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output mcuup_pkg::out_t out_item
);

  logic              push;
  logic              pop;
  mcuup_pkg::work_t  push_item;
  mcuup_pkg::work_t  head;
  mcuup_pkg::qstat_t qstat;

  mcuup_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .push      (push),
    .push_item (push_item),
    .qstat     (qstat)
  );

  mcuup_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  mcuup_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // The queue is never full and empty at once
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

  // Input back-pressure only arises once the queue holds items
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !qstat.empty)
    else $error("input stalled with an empty queue");

  // No pixel appears straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // Nothing leaves an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !pop)
    else $error("pop from an empty queue");

endmodule
